// ===== rtl/cdsd_pkg.sv =====
// cdsd_pkg: mode codes, result type and digit helpers for the clock display scan driver
// no dependencies; imported by cdsd_scan_logic, clock_display_scan_driver_core, scan_check_pkg and the test
package cdsd_pkg;

    localparam logic [2:0] MODE_SHOW_TIME    = 3'd0;
    localparam logic [2:0] MODE_ADJ_HOUR     = 3'd1;
    localparam logic [2:0] MODE_ADJ_MINUTE   = 3'd2;
    localparam logic [2:0] MODE_SHOW_ALARM   = 3'd3;
    localparam logic [2:0] MODE_ADJ_ALARM    = 3'd4;

    localparam logic [1:0] POS_HOUR_TENS     = 2'd0;
    localparam logic [1:0] POS_HOUR_UNITS    = 2'd1;
    localparam logic [1:0] POS_MINUTE_TENS   = 2'd2;
    localparam logic [1:0] POS_MINUTE_UNITS  = 2'd3;

    localparam logic [7:0] BLINK_THRESHOLD_RESET = 8'd63;

    typedef struct packed {
        logic [3:0] digit_enable;
        logic [6:0] segments;
        logic       colon_lit;
    } t_result;

    // tens digit of a 6-bit value (0..63)
    function automatic logic [3:0] tens_of(input logic [5:0] value);
        logic [3:0] tens;
        if (value >= 6'd60)      tens = 4'd6;
        else if (value >= 6'd50) tens = 4'd5;
        else if (value >= 6'd40) tens = 4'd4;
        else if (value >= 6'd30) tens = 4'd3;
        else if (value >= 6'd20) tens = 4'd2;
        else if (value >= 6'd10) tens = 4'd1;
        else                     tens = 4'd0;
        return tens;
    endfunction

    // units digit given the value and its tens digit
    function automatic logic [3:0] units_of(input logic [5:0] value, input logic [3:0] tens);
        logic [6:0] tens_x10;
        logic [6:0] diff;
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        diff     = {1'b0, value} - tens_x10;
        return diff[3:0];
    endfunction

    // seven-segment pattern, a..g on bits 0..6
    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] segs;
        case (digit)
            4'd0:    segs = 7'h3F;
            4'd1:    segs = 7'h06;
            4'd2:    segs = 7'h5B;
            4'd3:    segs = 7'h4F;
            4'd4:    segs = 7'h66;
            4'd5:    segs = 7'h6D;
            4'd6:    segs = 7'h7D;
            4'd7:    segs = 7'h07;
            4'd8:    segs = 7'h7F;
            4'd9:    segs = 7'h6F;
            default: segs = 7'h00;
        endcase
        return segs;
    endfunction

endpackage

// ===== rtl/cdsd_scan_logic.sv =====
// cdsd_scan_logic: combinational decode of one scan tick into digit enable, segments and colon
// depends on cdsd_pkg
module cdsd_scan_logic (
    input  logic [2:0]       i_mode,
    input  logic [1:0]       i_pos,
    input  logic             i_phase,
    input  logic [4:0]       i_time_hour,
    input  logic [5:0]       i_time_minute,
    input  logic [4:0]       i_alarm_hour,
    input  logic [5:0]       i_alarm_minute,
    output cdsd_pkg::t_result o_result
);
    import cdsd_pkg::*;

    logic [5:0] hour;
    logic [5:0] minute;
    logic [3:0] hour_tens;
    logic [3:0] minute_tens;
    logic [3:0] digit;
    logic       show;
    logic       colon;
    logic       left_pair;

    assign left_pair = (i_pos == POS_HOUR_TENS) || (i_pos == POS_HOUR_UNITS);

    always_comb begin
        hour   = {1'b0, i_time_hour};
        minute = i_time_minute;
        show   = 1'b0;
        colon  = 1'b0;
        // the show flag is recomputed on every tick, so the pair under
        // adjustment follows the blink phase directly
        unique case (i_mode)
            MODE_SHOW_TIME: begin
                show  = 1'b1;
                colon = 1'b1;
            end
            MODE_ADJ_HOUR: begin
                show  = left_pair ? i_phase : 1'b1;
                colon = i_phase;
            end
            MODE_ADJ_MINUTE: begin
                show  = left_pair ? 1'b1 : i_phase;
                colon = i_phase;
            end
            MODE_SHOW_ALARM: begin
                hour   = {1'b0, i_alarm_hour};
                minute = i_alarm_minute;
                show   = 1'b1;
                colon  = 1'b1;
            end
            MODE_ADJ_ALARM: begin
                hour   = {1'b0, i_alarm_hour};
                minute = i_alarm_minute;
                show   = 1'b1;
                colon  = i_phase;
            end
            default: begin
                show  = 1'b0;
                colon = 1'b0;
            end
        endcase
    end

    assign hour_tens   = tens_of(hour);
    assign minute_tens = tens_of(minute);

    always_comb begin
        unique case (i_pos)
            POS_HOUR_TENS:   digit = hour_tens;
            POS_HOUR_UNITS:  digit = units_of(hour, hour_tens);
            POS_MINUTE_TENS: digit = minute_tens;
            default:         digit = units_of(minute, minute_tens);
        endcase
    end

    always_comb begin
        o_result.colon_lit    = colon;
        o_result.digit_enable = 4'd0;
        o_result.segments     = 7'd0;
        // leading zero of the hour is blanked
        if (show && !((i_pos == POS_HOUR_TENS) && (digit == 4'd0))) begin
            o_result.digit_enable = 4'd1 << i_pos;
            o_result.segments     = seg_of(digit);
        end
    end

endmodule

// ===== rtl/clock_display_scan_driver_core.sv =====
// clock_display_scan_driver_core: top level of the four-digit multiplexed display scan driver
// depends on cdsd_pkg and cdsd_scan_logic
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one scan tick per transaction: display
//   mode, clock time and alarm time. Each accepted tick advances the digit position and
//   the blink timer, then yields exactly one result transaction on the output channel
//   (o_out_valid / i_out_ready): one-hot digit enable, segments a..g and the colon.
//   The blink threshold is written through i_cfg_wr_en / i_cfg_wr_data; the user must
//   do so only while idle, as the block itself does not enforce it.
//   Throughput: one tick per clock while o_in_ready is high; the position counter, blink
//   timer and digit decode feed the output register combinationally from the input handshake.
//   A skid register behind the output register lets a tick be accepted while a result
//   waits; o_in_ready drops only when both hold results, and rises again once the
//   receiver takes one.
//   Reset (synchronous, active low): position 0, blink timer 0, threshold 63, both
//   output buffers empty.
module clock_display_scan_driver_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic [4:0] i_time_hour,
    input  logic [5:0] i_time_minute,
    input  logic [4:0] i_alarm_hour,
    input  logic [5:0] i_alarm_minute,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_digit_enable,
    output logic [6:0] o_segments,
    output logic       o_colon_lit,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);
    import cdsd_pkg::*;

    logic [7:0] r_threshold;
    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [7:0] r_timer;
    logic [7:0] n_timer;
    logic       phase;
    logic       in_acc;
    logic       out_acc;
    t_result    new_result;
    t_result    r_out;
    t_result    r_skid;
    logic       r_out_valid;
    logic       r_skid_valid;

    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;

    assign n_pos   = r_pos + 2'd1;
    assign n_timer = r_timer + 8'd1;
    assign phase   = n_timer > r_threshold;

    cdsd_scan_logic u_scan (
        .i_mode         (i_mode),
        .i_pos          (n_pos),
        .i_phase        (phase),
        .i_time_hour    (i_time_hour),
        .i_time_minute  (i_time_minute),
        .i_alarm_hour   (i_alarm_hour),
        .i_alarm_minute (i_alarm_minute),
        .o_result       (new_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= BLINK_THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_timer <= 8'd0;
        end else if (in_acc) begin
            r_pos   <= n_pos;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_acc) begin
            // skid holds the older result, so it drains first
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_acc) begin
            r_out <= r_skid_valid ? r_skid : new_result;
        end
        if (r_out_valid && !out_acc && in_acc) begin
            r_skid <= new_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digit_enable = r_out.digit_enable;
    assign o_segments     = r_out.segments;
    assign o_colon_lit    = r_out.colon_lit;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_acc) |=> (r_pos == $past(r_pos) + 2'd1)
                                && (r_timer == $past(r_timer) + 8'd1))
        else $error("scan counters did not advance on an accepted transaction");

    a_pos_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !in_acc) |=> $stable(r_pos) && $stable(r_timer))
        else $error("scan counters moved without an accepted transaction");

    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_digit_enable))
        else $error("more than one digit enabled");

    a_blank_no_segments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_digit_enable == 4'd0)) |-> (o_segments == 7'd0))
        else $error("segments driven on a blanked digit");

endmodule

// ===== verif/scan_check_pkg.sv =====
`timescale 1ns / 100ps
// scan_check_pkg: scan tick type and the scoreboard for the clock display scan driver test
// depends on cdsd_pkg for the mode and position codes and the result type
package scan_check_pkg;

    import cdsd_pkg::*;

    localparam logic [2:0] MODE_BLANK_FIRST = 3'd5;
    localparam logic [2:0] MODE_BLANK_LAST  = 3'd7;
    localparam int unsigned REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] time_hour;
        logic [5:0] time_minute;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
    } t_scan_tick;

    class scan_scoreboard;
        t_result     expected_frames[$];
        logic [7:0]  blink_threshold;
        logic [1:0]  scan_pos;
        logic [7:0]  blink_timer;
        logic        left_shown;
        logic        right_shown;
        int unsigned mismatches;

        function new();
            blink_threshold = BLINK_THRESHOLD_RESET;
            scan_pos        = '0;
            blink_timer     = '0;
            left_shown      = 1'b1;
            right_shown     = 1'b1;
            mismatches      = 0;
        endfunction

        function void set_threshold(logic [7:0] value);
            blink_threshold = value;
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        // one display frame per scan tick: advance counters, pick and decode the digit
        function t_result predict_frame(t_scan_tick tick);
            t_result    frame;
            logic       phase;
            logic       show;
            logic [4:0] hour;
            logic [5:0] minute;
            int         digit;
            frame       = '0;
            scan_pos    = scan_pos + 2'd1;
            blink_timer = blink_timer + 8'd1;
            phase       = blink_timer > blink_threshold;
            case (tick.mode)
                MODE_SHOW_TIME: begin
                    frame.colon_lit = 1'b1;
                    left_shown      = 1'b1;
                    right_shown     = 1'b1;
                end
                MODE_ADJ_HOUR: begin
                    frame.colon_lit = phase;
                    right_shown     = 1'b1;
                    left_shown      = phase;
                end
                MODE_ADJ_MINUTE: begin
                    frame.colon_lit = phase;
                    left_shown      = 1'b1;
                    right_shown     = phase;
                end
                MODE_SHOW_ALARM: frame.colon_lit = 1'b1;
                MODE_ADJ_ALARM:  frame.colon_lit = phase;
                default:         frame.colon_lit = 1'b0;
            endcase
            if (tick.mode <= MODE_ADJ_MINUTE) begin
                hour   = tick.time_hour;
                minute = tick.time_minute;
                show   = (scan_pos < POS_MINUTE_TENS) ? left_shown : right_shown;
            end else if (tick.mode <= MODE_ADJ_ALARM) begin
                hour   = tick.alarm_hour;
                minute = tick.alarm_minute;
                show   = 1'b1;
            end else begin
                hour   = '0;
                minute = '0;
                show   = 1'b0;
            end
            case (scan_pos)
                POS_HOUR_TENS:   digit = int'(hour) / 10;
                POS_HOUR_UNITS:  digit = int'(hour) % 10;
                POS_MINUTE_TENS: digit = int'(minute) / 10;
                default:         digit = int'(minute) % 10;
            endcase
            // leading zero of the hour is dark
            if (show && !(scan_pos == POS_HOUR_TENS && digit == 0)) begin
                frame.digit_enable = 4'b0001 << scan_pos;
                case (digit)
                    0:       frame.segments = 7'h3F;
                    1:       frame.segments = 7'h06;
                    2:       frame.segments = 7'h5B;
                    3:       frame.segments = 7'h4F;
                    4:       frame.segments = 7'h66;
                    5:       frame.segments = 7'h6D;
                    6:       frame.segments = 7'h7D;
                    7:       frame.segments = 7'h07;
                    8:       frame.segments = 7'h7F;
                    9:       frame.segments = 7'h6F;
                    default: frame.segments = 7'h00;
                endcase
            end
            return frame;
        endfunction

        function void note_tick(t_scan_tick tick);
            expected_frames.push_back(predict_frame(tick));
        endfunction

        function void check_frame(t_result got);
            t_result want;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: enable %b segments %h colon %b",
                             got.digit_enable, got.segments, got.colon_lit);
                return;
            end
            want = expected_frames.pop_front();
            if (got.digit_enable !== want.digit_enable || got.segments !== want.segments ||
                got.colon_lit !== want.colon_lit) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected enable %b segments %h colon %b, got %b %h %b",
                             want.digit_enable, want.segments, want.colon_lit,
                             got.digit_enable, got.segments, got.colon_lit);
            end
        endfunction
    endclass

endpackage

// ===== verif/clock_display_scan_driver_core_test.sv =====
`timescale 1ns / 100ps
// clock_display_scan_driver_core_test: drives scan ticks with random idling and checks frames
// depends on cdsd_pkg, scan_check_pkg and the clock_display_scan_driver_core rtl
module clock_display_scan_driver_core_test;

    import cdsd_pkg::*;
    import scan_check_pkg::*;

    localparam int          RESET_CYCLES     = 12;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT      = 300000;
    localparam int          PHASE_TICKS      = 150;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_mode         = '0;
    logic [4:0] i_time_hour    = '0;
    logic [5:0] i_time_minute  = '0;
    logic [4:0] i_alarm_hour   = '0;
    logic [5:0] i_alarm_minute = '0;
    logic       o_out_valid;
    logic       i_out_ready    = 1'b0;
    logic [3:0] o_digit_enable;
    logic [6:0] o_segments;
    logic       o_colon_lit;
    logic       i_cfg_wr_en    = 1'b0;
    logic [7:0] i_cfg_wr_data  = '0;

    scan_scoreboard sb;
    int unsigned    cycle_count     = 0;
    int             holds_requested = 0;
    int             holds_done      = 0;
    bit             sender_eager    = 1'b0;
    bit             sender_rush     = 1'b0;

    clock_display_scan_driver_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_time_hour    (i_time_hour),
        .i_time_minute  (i_time_minute),
        .i_alarm_hour   (i_alarm_hour),
        .i_alarm_minute (i_alarm_minute),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digit_enable (o_digit_enable),
        .o_segments     (o_segments),
        .o_colon_lit    (o_colon_lit),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_frame(t_result'({o_digit_enable, o_segments, o_colon_lit}));
    end

    // receiver: random stall per result, with one long hold-off on request
    initial begin : receiver
        int stall;
        bit eager;
        eager = 1'b0;
        forever begin
            if (holds_done < holds_requested) begin
                holds_done++;
                stall = LONG_HOLD_CYCLES;
            end else begin
                if ($urandom_range(0, 31) == 0)
                    eager = !eager;
                stall = eager ? 0 : $urandom_range(0, 17);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    // valid stays high across back-to-back transactions when the gap is zero
    task automatic send_tick(input t_scan_tick tick);
        int gap;
        if ($urandom_range(0, 31) == 0)
            sender_eager = !sender_eager;
        gap = (sender_eager || sender_rush) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= tick.mode;
        i_time_hour    <= tick.time_hour;
        i_time_minute  <= tick.time_minute;
        i_alarm_hour   <= tick.alarm_hour;
        i_alarm_minute <= tick.alarm_minute;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(tick);
    endtask

    task automatic idle_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        idle_until_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_threshold(value);
    endtask

    // four ticks per display mode so every position is seen, then the blank modes
    function automatic t_scan_tick directed_tick(input int idx);
        t_scan_tick tick;
        logic [4:0] hour_picks   [6];
        logic [5:0] minute_picks [6];
        hour_picks   = '{5'd0, 5'd23, 5'd31, 5'd9, 5'd10, 5'd19};
        minute_picks = '{6'd0, 6'd59, 6'd63, 6'd9, 6'd32, 6'd40};
        tick.mode         = (idx < 20) ? 3'(idx / 4) : 3'(MODE_BLANK_FIRST + 3'(idx - 20));
        tick.time_hour    = hour_picks[idx % 6];
        tick.time_minute  = minute_picks[(idx + 1) % 6];
        tick.alarm_hour   = hour_picks[(idx + 3) % 6];
        tick.alarm_minute = minute_picks[(idx + 4) % 6];
        return tick;
    endfunction

    // mostly legal clock values, now and then the full field range
    function automatic t_scan_tick random_tick(input logic [2:0] mode);
        t_scan_tick tick;
        tick.mode         = mode;
        tick.time_hour    = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(0, 23));
        tick.time_minute  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 59));
        tick.alarm_hour   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(0, 23));
        tick.alarm_minute = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 59));
        return tick;
    endfunction

    initial begin : stimulus
        logic [7:0] thresholds [6];
        int         run_left;
        logic [2:0] run_mode;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks run with the reset threshold
        for (int i = 0; i < 23; i++)
            send_tick(directed_tick(i));

        thresholds = '{8'd0, 8'd255, 8'($urandom_range(0, 255)), 8'd1, 8'd254,
                       8'($urandom_range(0, 255))};
        run_left = 0;
        run_mode = MODE_SHOW_TIME;
        for (int p = 0; p < 6; p++) begin
            write_threshold(thresholds[p]);
            if (p == 1)
                holds_requested++;
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // keep offering while the receiver holds off so the block backs up
                sender_rush = (p == 1) && (n < 40);
                if (p == 3 && n == PHASE_TICKS / 2)
                    idle_until_drained();
                // a display sits in one mode for a run of ticks
                if (run_left == 0) begin
                    if ($urandom_range(0, 7) == 0)
                        run_mode = 3'($urandom_range(MODE_BLANK_FIRST, MODE_BLANK_LAST));
                    else
                        run_mode = 3'($urandom_range(MODE_SHOW_TIME, MODE_ADJ_ALARM));
                    run_left = $urandom_range(1, 32);
                end
                run_left--;
                send_tick(random_tick(run_mode));
            end
        end
        sender_rush = 1'b0;

        idle_until_drained();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
